FILE: rtl/core/ldkc_pkg.sv
// ldkc_pkg: shared types and constants for the LAN datagram kind classifier
// header layout, kind codes, register indexes and fixed datagram lengths
// no dependencies
`default_nettype none

package ldkc_pkg;

   // counter width default (range 8 to 32)
   localparam int CountBitsDefault = 16;

   // header layout
   localparam int HeaderBytes  = 16;
   localparam int LengthOffset = 0;
   localparam int TypeOffset   = 4;
   localparam int LengthBytes  = 4;
   localparam int TypeBytes    = 2;
   localparam int MarkAPos     = 'h10;
   localparam int MarkBPos     = 'h11;

   localparam int LengthBits = 8 * LengthBytes;
   localparam int TypeBits   = 8 * TypeBytes;

   // result codes
   localparam int KindBits = 4;
   typedef enum logic [KindBits-1:0] {
      KindUnknown    = 4'd0,
      KindPing       = 4'd1,
      KindRetransmit = 4'd2,
      KindControl    = 4'd3,
      KindWatchdog   = 4'd4,
      KindToken      = 4'd5,
      KindStatus     = 4'd6,
      KindLoginResp  = 4'd7,
      KindLogin      = 4'd8,
      KindConnInfo   = 4'd9,
      KindOpenClose  = 4'd10,
      KindCaps       = 4'd11,
      KindCiv        = 4'd12,
      KindAudio      = 4'd13
   } kind_type;

   // fixed declared lengths
   localparam logic [LengthBits-1:0] LenControl   = LengthBits'(HeaderBytes);
   localparam logic [LengthBits-1:0] LenWatchdog  = 32'h14;
   localparam logic [LengthBits-1:0] LenToken     = 32'h40;
   localparam logic [LengthBits-1:0] LenStatus    = 32'h50;
   localparam logic [LengthBits-1:0] LenLoginResp = 32'h60;
   localparam logic [LengthBits-1:0] LenLogin     = 32'h80;
   localparam logic [LengthBits-1:0] LenConnInfo  = 32'h90;
   localparam logic [LengthBits-1:0] LenOpenClose = 32'h16;
   localparam logic [LengthBits-1:0] LenCivMin    = 32'h15;
   localparam logic [LengthBits-1:0] LenAudioMin  = 32'h18;

   // capabilities: base + n * step, n >= 1
   localparam int CapsBase = 'h42;
   localparam int CapsStep = 'h66;
   localparam logic [LengthBits-1:0] LenCapsMin = LengthBits'(CapsBase + CapsStep);
   // step is 2 * 51 and 256 is 1 mod 51: residue mod 51 is a byte sum
   localparam int CapsOddFactor = CapsStep / 2;
   localparam int CapsResidue   = CapsBase % CapsOddFactor;

   // marker bytes
   localparam logic [7:0] MarkOpenA = 8'h01;
   localparam logic [7:0] MarkOpenB = 8'hc0;
   localparam logic [7:0] MarkCivA0 = 8'hc0;
   localparam logic [7:0] MarkCivA1 = 8'hc1;

   // configuration registers
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;
   localparam logic CsrPingIdx       = 1'b0;
   localparam logic CsrRetransmitIdx = 1'b1;
   localparam logic [TypeBits-1:0] PingCodeReset       = 16'd7;
   localparam logic [TypeBits-1:0] RetransmitCodeReset = 16'd1;

endpackage

`default_nettype wire

FILE: rtl/core/lan_datagram_kind_classifier.sv
// lan_datagram_kind_classifier: top level, byte capture and kind decision
// depends on ldkc_pkg
`default_nettype none

// Classifies one received UDP datagram that arrives as a stream of bytes,
// one byte per req_ transfer, with req_last set on the final byte. The block
// counts the bytes (saturating at COUNT_BITS bits) and captures the 32-bit
// little-endian declared length at offset 0, the 16-bit type at offset 4 and
// the bytes at offsets 0x10 and 0x11. For every final byte one rsp_ transfer
// carries rsp_kind; non-final bytes produce nothing. A byte is taken every
// cycle while the result side keeps up; the final byte's snapshot goes to a
// decision register, then to the result register that drives rsp_valid,
// and both registers let a stalled result wait while the next datagram
// streams in. Ready drops only while both registers hold results and
// rsp_ready is low.
// csr_ registers (byte address 4*i): 0 ping type code (reset 7),
// 1 retransmit type code (reset 1); write them only while the block is idle.
module lan_datagram_kind_classifier #(
   parameter int COUNT_BITS = ldkc_pkg::CountBitsDefault
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_last,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [ldkc_pkg::KindBits-1:0]         rsp_kind,

   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [ldkc_pkg::CsrAddrBits-1:0] csr_paddr,
   input  wire logic [ldkc_pkg::CsrDataBits-1:0] csr_pwdata,
   output logic [ldkc_pkg::CsrDataBits-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import ldkc_pkg::*;

   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   // configuration registers
   logic [TypeBits-1:0] ping_code_ff;
   logic [TypeBits-1:0] retx_code_ff;
   logic                csr_write;

   // datagram state, one per byte stream
   logic [COUNT_BITS-1:0] count_ff,  count_in;
   logic [LengthBits-1:0] length_ff, length_in;
   logic [TypeBits-1:0]   type_ff,   type_in;
   logic [7:0]            mark_a_ff, mark_a_in;
   logic [7:0]            mark_b_ff, mark_b_in;

   // decision register: snapshot of the finished datagram
   logic                  dec_valid_ff, dec_valid_in;
   logic [COUNT_BITS-1:0] dec_count_ff;
   logic [LengthBits-1:0] dec_length_ff;
   logic [TypeBits-1:0]   dec_type_ff;
   logic [7:0]            dec_mark_a_ff;
   logic [7:0]            dec_mark_b_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff,  rsp_kind_in;

   logic req_xfer;
   logic rsp_load;
   logic dec_load;

   //--------------------------------------------------------------------
   // configuration port
   //--------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ping_code_ff <= PingCodeReset;
         retx_code_ff <= RetransmitCodeReset;
      end else if (csr_write) begin
         // low address bits are ignored, bit 2 picks the register
         unique case (csr_paddr[2])
            CsrPingIdx:       ping_code_ff <= csr_pwdata[TypeBits-1:0];
            CsrRetransmitIdx: retx_code_ff <= csr_pwdata[TypeBits-1:0];
            default:          ping_code_ff <= ping_code_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CsrPingIdx:       csr_prdata = CsrDataBits'(ping_code_ff);
         CsrRetransmitIdx: csr_prdata = CsrDataBits'(retx_code_ff);
         default:          csr_prdata = '0;
      endcase
   end

   //--------------------------------------------------------------------
   // flow control
   //--------------------------------------------------------------------
   // result register frees up when empty or when its transfer completes
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   // decision register can take a new snapshot when empty or moving on
   assign dec_load  = !dec_valid_ff || rsp_load;
   assign req_ready = dec_load;
   assign req_xfer  = req_valid && req_ready;

   //--------------------------------------------------------------------
   // byte capture: next state of the current datagram
   //--------------------------------------------------------------------
   always_comb begin
      length_in = length_ff;
      type_in   = type_ff;
      mark_a_in = mark_a_ff;
      mark_b_in = mark_b_ff;

      // byte lands at the position the count points at (offsets may overlap)
      for (int k = 0; k < LengthBytes; k++) begin
         if (count_ff == COUNT_BITS'(LengthOffset + k)) begin
            length_in[8*k +: 8] = req_data_byte;
         end
      end
      for (int k = 0; k < TypeBytes; k++) begin
         if (count_ff == COUNT_BITS'(TypeOffset + k)) begin
            type_in[8*k +: 8] = req_data_byte;
         end
      end
      if (count_ff == COUNT_BITS'(MarkAPos)) begin
         mark_a_in = req_data_byte;
      end
      if (count_ff == COUNT_BITS'(MarkBPos)) begin
         mark_b_in = req_data_byte;
      end

      // count holds once saturated
      if (count_ff != CountMax) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         length_ff <= '0;
         type_ff   <= '0;
         mark_a_ff <= '0;
         mark_b_ff <= '0;
      end else if (req_xfer) begin
         if (req_last) begin
            // final byte: start the next datagram from a clean header
            count_ff  <= '0;
            length_ff <= '0;
            type_ff   <= '0;
            mark_a_ff <= '0;
            mark_b_ff <= '0;
         end else begin
            count_ff  <= count_in;
            length_ff <= length_in;
            type_ff   <= type_in;
            mark_a_ff <= mark_a_in;
            mark_b_ff <= mark_b_in;
         end
      end
   end

   //--------------------------------------------------------------------
   // decision register
   //--------------------------------------------------------------------
   always_comb begin
      if (req_xfer && req_last) begin
         dec_valid_in = 1'b1;
      end else if (rsp_load) begin
         dec_valid_in = 1'b0;
      end else begin
         dec_valid_in = dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && req_last) begin
         dec_count_ff  <= count_in;
         dec_length_ff <= length_in;
         dec_type_ff   <= type_in;
         dec_mark_a_ff <= mark_a_in;
         dec_mark_b_ff <= mark_b_in;
      end
   end

   //--------------------------------------------------------------------
   // kind decision
   //--------------------------------------------------------------------
   logic [LengthBits-1:0] rx_len;
   logic [9:0]            byte_sum;
   logic [8:0]            byte_fold;
   logic                  caps_step_ok;

   assign rx_len = LengthBits'(dec_count_ff);

   // length == base mod step: even, and byte sum folded mod 51 hits the
   // residue (fold is at most 258, so only a few candidates)
   always_comb begin
      byte_sum = '0;
      for (int k = 0; k < LengthBytes; k++) begin
         byte_sum = byte_sum + 10'(dec_length_ff[8*k +: 8]);
      end
      byte_fold    = 9'(byte_sum[7:0]) + 9'(byte_sum[9:8]);
      caps_step_ok = 1'b0;
      for (int k = 0; k < 6; k++) begin
         if (byte_fold == 9'(CapsResidue + k * CapsOddFactor)) begin
            caps_step_ok = 1'b1;
         end
      end
      caps_step_ok = caps_step_ok && !dec_length_ff[0];
   end

   always_comb begin
      priority if (rx_len < LengthBits'(HeaderBytes)) begin
         rsp_kind_in = KindUnknown;
      end else if (dec_type_ff == ping_code_ff) begin
         rsp_kind_in = KindPing;
      end else if (dec_type_ff == retx_code_ff) begin
         rsp_kind_in = KindRetransmit;
      end else if (dec_length_ff > rx_len) begin
         // header claims more than arrived
         rsp_kind_in = KindUnknown;
      end else if (dec_length_ff == LenControl) begin
         rsp_kind_in = KindControl;
      end else if (dec_length_ff == LenWatchdog) begin
         rsp_kind_in = KindWatchdog;
      end else if (dec_length_ff == LenToken) begin
         rsp_kind_in = KindToken;
      end else if (dec_length_ff == LenStatus) begin
         rsp_kind_in = KindStatus;
      end else if (dec_length_ff == LenLoginResp) begin
         rsp_kind_in = KindLoginResp;
      end else if (dec_length_ff == LenLogin) begin
         rsp_kind_in = KindLogin;
      end else if (dec_length_ff == LenConnInfo) begin
         rsp_kind_in = KindConnInfo;
      end else if (dec_length_ff == LenOpenClose && dec_mark_a_ff == MarkOpenA &&
                   dec_mark_b_ff == MarkOpenB) begin
         rsp_kind_in = KindOpenClose;
      end else if (dec_length_ff >= LenCapsMin && caps_step_ok) begin
         rsp_kind_in = KindCaps;
      end else if (dec_length_ff >= LenCivMin &&
                   (dec_mark_a_ff == MarkCivA0 || dec_mark_a_ff == MarkCivA1)) begin
         rsp_kind_in = KindCiv;
      end else if (dec_length_ff >= LenAudioMin) begin
         rsp_kind_in = KindAudio;
      end else begin
         rsp_kind_in = KindUnknown;
      end
   end

   //--------------------------------------------------------------------
   // result register
   //--------------------------------------------------------------------
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = dec_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && dec_valid_ff) begin
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;

endmodule

`default_nettype wire

FILE: test/lan_datagram_kind_classifier_test.sv
// lan_datagram_kind_classifier_test: self-checking bench for the datagram kind classifier
// streams whole datagrams through the req_/rsp_ handshakes with random idling and
// csr_ code changes, depends on ldkc_pkg and the classifier top level
`timescale 1ns / 1ps

module lan_datagram_kind_classifier_test;
   import ldkc_pkg::*;

   localparam int CountBits  = CountBitsDefault;
   localparam int CycleLimit = 1_000_000;
   localparam int NoPin      = -1;
   localparam int PhaseBytes = 120;

   // one directed datagram: bytes to send, header contents, optional typed kind
   typedef struct packed {
      int unsigned        rx;
      logic [31:0]        dlen;
      logic [15:0]        htype;
      logic [7:0]         mark_a;
      logic [7:0]         mark_b;
      logic               pinned;
      kind_type           want;
   } dgram_row_type;

   // fixed headers, markers and every decision rule
   localparam dgram_row_type Rows[24] = '{
      '{32'd1,     32'h10,        16'h0000,            8'h00,     8'h00,     1'b1, KindUnknown},
      '{32'd15,    32'h0f,        16'h0000,            8'h00,     8'h00,     1'b1, KindUnknown},
      '{32'd16,    LenControl,    16'h0000,            8'h00,     8'h00,     1'b1, KindControl},
      '{32'd16,    LenControl,    PingCodeReset,       8'h00,     8'h00,     1'b1, KindPing},
      '{32'd16,    32'h63,        RetransmitCodeReset, 8'h00,     8'h00,     1'b1, KindRetransmit},
      '{32'd16,    LenWatchdog,   16'h0002,            8'h00,     8'h00,     1'b1, KindUnknown},
      '{32'h14,    LenWatchdog,   16'h0002,            8'h00,     8'h00,     1'b1, KindWatchdog},
      '{32'h40,    LenToken,      16'h8000,            8'h00,     8'h00,     1'b1, KindToken},
      '{32'h50,    LenStatus,     16'h0000,            8'h00,     8'h00,     1'b1, KindStatus},
      '{32'h60,    LenLoginResp,  16'h0000,            8'h00,     8'h00,     1'b1, KindLoginResp},
      '{32'h80,    LenLogin,      16'h0000,            8'h00,     8'h00,     1'b1, KindLogin},
      '{32'h90,    LenConnInfo,   16'h0000,            8'h00,     8'h00,     1'b1, KindConnInfo},
      '{32'h16,    LenOpenClose,  16'h0000,            MarkOpenA, MarkOpenB, 1'b1, KindOpenClose},
      '{32'h16,    LenOpenClose,  16'h0000,            MarkCivA0, MarkOpenB, 1'b1, KindCiv},
      '{32'h16,    LenOpenClose,  16'h0000,            MarkOpenA, 8'h00,     1'b1, KindUnknown},
      '{32'ha8,    LenCapsMin,    16'h0000,            MarkCivA0, 8'h00,     1'b1, KindCaps},
      '{32'h42,    32'h42,        16'h0000,            8'h00,     8'h00,     1'b1, KindAudio},
      '{32'h15,    LenCivMin,     16'h0000,            MarkCivA1, 8'h00,     1'b1, KindCiv},
      '{32'h17,    32'h17,        16'h0000,            8'hff,     8'hff,     1'b1, KindUnknown},
      '{32'h18,    LenAudioMin,   16'h0000,            8'h00,     8'h00,     1'b1, KindAudio},
      '{32'h20,    LenAudioMin,   16'hffff,            8'h80,     8'h00,     1'b0, KindUnknown},
      '{32'd16,    32'h0,         16'h0000,            8'h00,     8'h00,     1'b1, KindUnknown},
      '{32'h30,    32'hffffffff,  16'hffff,            8'hff,     8'hff,     1'b1, KindUnknown},
      '{32'h10e,   32'h10e,       16'h5a5a,            MarkCivA1, 8'h00,     1'b0, KindUnknown}
   };

   logic                   clock;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = '0;
   logic                   req_last      = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [KindBits-1:0]    rsp_kind;
   logic                   csr_psel      = 1'b0;
   logic                   csr_penable   = 1'b0;
   logic                   csr_pwrite    = 1'b0;
   logic [CsrAddrBits-1:0] csr_paddr     = '0;
   logic [CsrDataBits-1:0] csr_pwdata    = '0;
   logic [CsrDataBits-1:0] csr_prdata;
   logic                   csr_pready;

   // predictor copy of the registers and of the per-datagram capture
   logic [15:0]            ping_code = PingCodeReset;
   logic [15:0]            retx_code = RetransmitCodeReset;
   logic [CountBits-1:0]   seen_count = '0;
   logic [31:0]            seen_len   = '0;
   logic [15:0]            seen_type  = '0;
   logic [7:0]             mark_a     = '0;
   logic [7:0]             mark_b     = '0;

   kind_type               pending_kinds[$];
   int                     pinned_kinds[$];
   int                     errors      = 0;
   int                     gap_pct     = 32;
   int unsigned            bytes_sent  = 0;
   int unsigned            dgrams_sent = 0;
   int unsigned            cycle_count = 0;

   lan_datagram_kind_classifier #(
      .COUNT_BITS(CountBits)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_byte(req_data_byte),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side stalls at the same rate as the sender idles
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= gap_pct);
   end

   // decision on the final byte, rules in priority order
   function automatic kind_type decide_kind();
      logic [31:0] rx;
      rx = 32'(seen_count);
      if (rx < 32'(HeaderBytes)) return KindUnknown;
      // type codes win over the length check
      if (seen_type == ping_code) return KindPing;
      if (seen_type == retx_code) return KindRetransmit;
      if (seen_len > rx) return KindUnknown;
      case (seen_len)
         LenControl:   return KindControl;
         LenWatchdog:  return KindWatchdog;
         LenToken:     return KindToken;
         LenStatus:    return KindStatus;
         LenLoginResp: return KindLoginResp;
         LenLogin:     return KindLogin;
         LenConnInfo:  return KindConnInfo;
         default: ;
      endcase
      if (seen_len == LenOpenClose && mark_a == MarkOpenA && mark_b == MarkOpenB)
         return KindOpenClose;
      // capabilities: base plus a whole number (at least one) of steps
      if (seen_len >= LenCapsMin && (seen_len - 32'(CapsBase)) % 32'(CapsStep) == 0)
         return KindCaps;
      if (seen_len >= LenCivMin) begin
         if (mark_a == MarkCivA0 || mark_a == MarkCivA1) return KindCiv;
         if (seen_len >= LenAudioMin) return KindAudio;
      end
      return KindUnknown;
   endfunction

   // capture one accepted byte, count it, and queue the kind on the final byte
   function automatic void absorb_byte(input logic [7:0] b, input logic fin);
      int unsigned pos;
      pos = 32'(seen_count);
      // unsigned difference wraps to a large value below the offset
      if (pos - LengthOffset < LengthBytes) seen_len[8*(pos - LengthOffset) +: 8] = b;
      if (pos - TypeOffset < TypeBytes) seen_type[8*(pos - TypeOffset) +: 8] = b;
      if (pos == MarkAPos) mark_a = b;
      if (pos == MarkBPos) mark_b = b;
      // count holds at its maximum
      if (seen_count != '1) seen_count = seen_count + 1'b1;
      if (fin) begin
         pending_kinds.push_back(decide_kind());
         seen_count = '0;
         seen_len   = '0;
         seen_type  = '0;
         mark_a     = '0;
         mark_b     = '0;
      end
   endfunction

   // compare one result transfer with the oldest expectation
   function automatic void check_kind(input logic [KindBits-1:0] got);
      kind_type want;
      int       pin;
      if (pending_kinds.size() == 0) begin
         $error("kind: result with nothing expected, actual %0d", got);
         errors++;
         return;
      end
      want = pending_kinds.pop_front();
      pin  = NoPin;
      if (pinned_kinds.size() != 0) pin = pinned_kinds.pop_front();
      // directed rows with a typed-in kind are checked against that value
      if (pin != NoPin) want = kind_type'(pin);
      if (got !== want) begin
         $error("kind mismatch: expected %0d, actual %0d", want, got);
         errors++;
      end
   endfunction

   // monitor: sample handshakes before this edge's updates land
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) absorb_byte(req_data_byte, req_last);
      if (!reset && rsp_valid && rsp_ready) check_kind(rsp_kind);
   end

   // byte at a wire position: header fields where they belong, random fill elsewhere
   function automatic logic [7:0] wire_byte(input int unsigned pos, input logic [31:0] dlen,
                                            input logic [15:0] htype, input logic [7:0] ma,
                                            input logic [7:0] mb);
      if (pos - LengthOffset < LengthBytes) return dlen[8*(pos - LengthOffset) +: 8];
      if (pos - TypeOffset < TypeBytes) return htype[8*(pos - TypeOffset) +: 8];
      if (pos == MarkAPos) return ma;
      if (pos == MarkBPos) return mb;
      return 8'($urandom);
   endfunction

   // stream one datagram, one transfer per byte, with random idle cycles between
   task automatic send_datagram(input int unsigned rx, input logic [31:0] dlen,
                                input logic [15:0] htype, input logic [7:0] ma,
                                input logic [7:0] mb);
      for (int unsigned pos = 0; pos < rx; pos++) begin
         while ($urandom_range(99) < gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= wire_byte(pos, dlen, htype, ma, mb);
         req_last      <= (pos == rx - 1);
         do @(posedge clock); while (!req_ready);
      end
      bytes_sent  += rx;
      dgrams_sent += 1;
   endtask

   // mostly well-formed datagrams with random content, some cut or padded, some noise
   task automatic send_random_datagram();
      int unsigned rx;
      logic [31:0] dlen;
      logic [15:0] htype;
      logic [7:0]  ma;
      logic [7:0]  mb;
      htype = 16'($urandom);
      ma    = 8'($urandom);
      mb    = 8'($urandom);
      case ($urandom_range(9))
         0: htype = ping_code;
         1: htype = retx_code;
         2: htype = '0;
         3: htype = '1;
         default: ;
      endcase
      if ($urandom_range(99) < 12) begin
         // noise: random length field, short random byte run
         dlen = $urandom;
         rx   = $urandom_range(1, 40);
      end else begin
         case ($urandom_range(15))
            0, 1:    dlen = LenControl;
            2, 3:    dlen = LenWatchdog;
            4, 5, 6: dlen = LenOpenClose;
            7, 8, 9: dlen = $urandom_range(LenCivMin, 48);
            10:      dlen = LenToken;
            11:      dlen = LenStatus;
            12:      dlen = LenLoginResp;
            13:      dlen = LenLogin;
            14:      dlen = LenConnInfo;
            default: dlen = 32'(CapsBase + CapsStep * $urandom_range(1, 2));
         endcase
         case ($urandom_range(3))
            0: ma = MarkOpenA;
            1: ma = MarkCivA0;
            2: ma = MarkCivA1;
            default: ;
         endcase
         if ($urandom_range(1) == 1) mb = MarkOpenB;
         case ($urandom_range(19))
            0, 1:    rx = dlen + $urandom_range(1, 8);  // trailing bytes
            2, 3, 4: rx = $urandom_range(1, dlen - 1);  // cut short
            default: rx = dlen;
         endcase
      end
      send_datagram(rx, dlen, htype, ma, mb);
   endtask

   // one register transfer: setup then access; reads are checked against the copy
   task automatic csr_access(input logic idx, input logic wr, input logic [15:0] value);
      logic [15:0] held;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CsrAddrBits'({idx, 2'b00});
      csr_pwdata  <= CsrDataBits'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      held = (idx == CsrPingIdx) ? ping_code : retx_code;
      if (wr) begin
         if (idx == CsrPingIdx) ping_code = value;
         else retx_code = value;
      end else if (csr_prdata !== CsrDataBits'(held)) begin
         $error("prdata mismatch: expected %0h, actual %0h", held, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // let every expected kind arrive, then a few cycles for the two result stages
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_kinds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [15:0] next_ping;
      logic [15:0] next_retx;
      int unsigned phase_bytes;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values read back
      csr_access(CsrPingIdx, 1'b0, '0);
      csr_access(CsrRetransmitIdx, 1'b0, '0);

      // directed datagrams under the reset codes
      foreach (Rows[i]) begin
         pinned_kinds.push_back(Rows[i].pinned ? int'(Rows[i].want) : NoPin);
         send_datagram(Rows[i].rx, Rows[i].dlen, Rows[i].htype, Rows[i].mark_a,
                       Rows[i].mark_b);
      end

      // random phases, each under its own pair of type codes; the second runs without idling
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               next_ping = '0;
               next_retx = '1;
            end
            1: begin
               next_ping = '1;
               next_retx = '0;
            end
            2: begin
               // equal codes: ping has priority
               next_ping = 16'($urandom);
               next_retx = next_ping;
            end
            default: begin
               next_ping = 16'($urandom);
               next_retx = 16'($urandom);
            end
         endcase
         drain_results();
         csr_access(CsrPingIdx, 1'b1, next_ping);
         csr_access(CsrRetransmitIdx, 1'b1, next_retx);
         csr_access(CsrPingIdx, 1'b0, '0);
         csr_access(CsrRetransmitIdx, 1'b0, '0);
         gap_pct     = (p == 1) ? 0 : 32;
         phase_bytes = bytes_sent;
         while (bytes_sent - phase_bytes < PhaseBytes)
            send_random_datagram();
      end

      drain_results();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
